>>> design/minq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minq_pkg
// field widths, stream layout and codes shared by the min queue design
// ----------------------------------------------------------------------------
package minq_pkg;

    localparam int VALUE_W     = 32;
    localparam int OCC_W       = 11;
    localparam int STATUS_W    = 2;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam t_status STS_OK    = 2'd0;
    localparam t_status STS_EMPTY = 2'd1;
    localparam t_status STS_FULL  = 2'd2;

endpackage

>>> design/min_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_queue
// fifo of signed values that reports the minimum of its contents
// ----------------------------------------------------------------------------
// Each transaction is a push or a pop and yields one result transaction with
// the minimum of all held values (0 when empty), the occupancy and a status.
// The queue is two stacks in single-port memories, each top minimum cached in
// a register. A push or a pop from a non-empty front stack goes from
// acceptance through the execute state to the result state, by way of a read
// state when the new front top must be read back. A pop on an empty front
// stack first moves the back stack over, one element per cycle. Every element
// is moved at most once. The next transaction is accepted as soon as the
// sequencer is idle while an untaken result waits in the output register; a
// new result holds the sequencer until the previous one is taken.
// ----------------------------------------------------------------------------
module min_queue #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [minq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // value
    input  logic [minq_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // operation
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [minq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // min_value, occupancy, zero pad
    output logic [minq_pkg::OUT_TUSER_W-1:0]   m_axis_tuser   // status
);
    import minq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PAD_W = OUT_TDATA_W - VALUE_W - OCC_W;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_MOVE   = 3'd2;
    localparam logic [2:0] S_RDTOP  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]                   r_state;
    logic                         r_op;
    logic signed [DATA_WIDTH-1:0] r_value;
    logic [CW-1:0]                r_back_cnt;
    logic [CW-1:0]                r_front_cnt;
    logic signed [DATA_WIDTH-1:0] r_back_top;
    logic signed [DATA_WIDTH-1:0] r_front_top;
    t_status                      r_status;
    logic                         r_out_valid;
    logic [VALUE_W-1:0]           r_out_min;
    logic [OCC_W-1:0]             r_out_occ;
    t_status                      r_out_status;

    logic signed [DATA_WIDTH-1:0] r_back_mem  [CAPACITY];
    logic signed [DATA_WIDTH-1:0] r_front_mem [CAPACITY];
    logic signed [DATA_WIDTH-1:0] r_back_rd;
    logic signed [DATA_WIDTH-1:0] r_front_rd;

    logic                         accept;
    logic                         out_load;
    logic [CW-1:0]                total;
    logic                         is_full;
    logic                         is_empty;
    logic [CW-1:0]                back_last;
    logic [CW-1:0]                front_prev;
    logic signed [DATA_WIDTH-1:0] push_mn;
    logic signed [DATA_WIDTH-1:0] move_mn;
    logic signed [DATA_WIDTH-1:0] q_min;
    logic [CW+OCC_W-1:0]          occ_ext;
    logic                         back_we;
    logic                         back_re;
    logic                         front_we;
    logic                         front_re;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_RESULT) && (!r_out_valid || m_axis_tready);

    assign total      = r_back_cnt + r_front_cnt;
    assign is_full    = (total == CAP_C);
    assign is_empty   = (total == '0);
    assign back_last  = r_back_cnt - ONE_C;
    assign front_prev = r_front_cnt - TWO_C;
    assign occ_ext    = {{OCC_W{1'b0}}, total};

    assign push_mn = ((r_back_cnt == '0) || (r_value < r_back_top)) ? r_value : r_back_top;
    assign move_mn = ((r_front_cnt == '0) || (r_back_rd < r_front_top)) ? r_back_rd
                                                                        : r_front_top;

    always_comb begin
        if ((r_back_cnt != '0) && (r_front_cnt != '0)) begin
            q_min = (r_back_top < r_front_top) ? r_back_top : r_front_top;
        end else if (r_back_cnt != '0) begin
            q_min = r_back_top;
        end else if (r_front_cnt != '0) begin
            q_min = r_front_top;
        end else begin
            q_min = '0;
        end
    end

    assign back_we  = (r_state == S_EXEC) && (r_op == OP_PUSH) && !is_full;
    assign back_re  = ((r_state == S_EXEC) && (r_op == OP_POP) && !is_empty
                       && (r_front_cnt == '0))
                   || ((r_state == S_MOVE) && (r_back_cnt != '0));
    assign front_we = (r_state == S_MOVE) && (r_back_cnt != '0);
    assign front_re = (r_state == S_EXEC) && (r_op == OP_POP) && !is_empty
                   && (r_front_cnt >= TWO_C);

    // stack memories
    always_ff @(posedge i_clk) begin
        if (back_we) begin
            r_back_mem[r_back_cnt[AW-1:0]] <= r_value;
        end
        if (back_re) begin
            r_back_rd <= r_back_mem[back_last[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_we) begin
            r_front_mem[r_front_cnt[AW-1:0]] <= move_mn;
        end
        if (front_re) begin
            r_front_rd <= r_front_mem[front_prev[AW-1:0]];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_back_cnt  <= '0;
            r_front_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= s_axis_tuser[0];
                        r_value <= s_axis_tdata[DATA_WIDTH-1:0];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_PUSH) begin
                        if (is_full) begin
                            r_status <= STS_FULL;
                        end else begin
                            r_status   <= STS_OK;
                            r_back_top <= push_mn;
                            r_back_cnt <= r_back_cnt + ONE_C;
                        end
                        r_state <= S_RESULT;
                    end else if (is_empty) begin
                        r_status <= STS_EMPTY;
                        r_state  <= S_RESULT;
                    end else if (r_front_cnt == '0) begin
                        r_status   <= STS_OK;
                        r_back_cnt <= back_last;
                        r_state    <= S_MOVE;
                    end else begin
                        r_status    <= STS_OK;
                        r_front_cnt <= r_front_cnt - ONE_C;
                        r_state     <= (r_front_cnt >= TWO_C) ? S_RDTOP : S_RESULT;
                    end
                end
                S_MOVE: begin
                    // the last element moved is the one popped, so it is dropped
                    if (r_back_cnt != '0) begin
                        r_back_cnt  <= back_last;
                        r_front_cnt <= r_front_cnt + ONE_C;
                        r_front_top <= move_mn;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_RDTOP: begin
                    r_front_top <= r_front_rd;
                    r_state     <= S_RESULT;
                end
                S_RESULT: begin
                    if (out_load) begin
                        r_out_min    <= VALUE_W'(q_min);
                        r_out_occ    <= occ_ext[OCC_W-1:0];
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_occ, r_out_min};
    assign m_axis_tuser  = r_out_status;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_back_cnt} + {1'b0, r_front_cnt}) <= {1'b0, CAP_C})
        else $error("occupancy above capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                               && $stable(m_axis_tuser)))
        else $error("result changed while waiting");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STS_EMPTY)) |-> ((r_out_occ == '0) && (r_out_min == '0)))
        else $error("underflow result with nonzero occupancy or minimum");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the min queue
// ----------------------------------------------------------------------------
// Pushes and pops are driven on the input stream with random gaps while the
// result stream stalls at random. A scoreboard keeps its own copy of the queue
// contents, predicts minimum, occupancy and status for every accepted request
// and compares each result in order. Directed requests cover the empty and
// extreme-value cases. A push-heavy phase builds a deep queue, a drain runs
// it below empty, and the run ends with a stretch without gaps or stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import minq_pkg::*;

    localparam int CAPACITY    = 1024;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic signed [VALUE_W-1:0] min_value;
        logic [OCC_W-1:0]          occupancy;
        t_status                   status;
    } t_queue_report;

    class minq_scoreboard;
        logic signed [VALUE_W-1:0] held[$];
        t_queue_report             expected[$];
        int                        capacity;
        int                        errors;

        function new(int cap);
            capacity = cap;
            errors   = 0;
        endfunction

        function int occupancy();
            return held.size();
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void note_request(logic op, logic [VALUE_W-1:0] value);
            t_queue_report r;
            r.status = STS_OK;
            if (op == OP_PUSH) begin
                if (held.size() >= capacity) begin
                    r.status = STS_FULL;
                end else begin
                    held.push_back(value);
                end
            end else begin
                if (held.size() == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    void'(held.pop_front());
                end
            end
            r.occupancy = held.size();
            r.min_value = '0;
            foreach (held[i]) begin
                if (i == 0 || held[i] < r.min_value) begin
                    r.min_value = held[i];
                end
            end
            expected.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, t_status status);
            t_queue_report r;
            logic signed [VALUE_W-1:0] got_min;
            logic [OCC_W-1:0] got_occ;
            got_min = data[VALUE_W-1:0];
            got_occ = data[VALUE_W+OCC_W-1:VALUE_W];
            if (expected.size() == 0) begin
                $display("%0t: unexpected result min %0d occupancy %0d status %0d",
                         $time, got_min, got_occ, status);
                errors++;
                return;
            end
            r = expected.pop_front();
            if (got_min !== r.min_value) begin
                $display("%0t: min_value mismatch expected %0d actual %0d",
                         $time, r.min_value, got_min);
                errors++;
            end
            if (got_occ !== r.occupancy) begin
                $display("%0t: occupancy mismatch expected %0d actual %0d",
                         $time, r.occupancy, got_occ);
                errors++;
            end
            if (status !== r.status) begin
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, r.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // value
    logic [IN_TUSER_W-1:0]  s_axis_tuser;   // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // min_value, occupancy, zero pad
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // status

    minq_scoreboard sb;
    int             send_idle_pct;
    int             recv_idle_pct;
    bit             quiet;
    int             cycles;

    min_queue #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (VALUE_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result checked before the new request is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(s_axis_tuser[0], s_axis_tdata);
            end
        end
    end

    // result side stalls
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
                stall_left = $urandom_range(1, 6) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_pressure();
        case ($urandom_range(0, 3))
            0:       send_idle_pct = 0;
            1:       send_idle_pct = 10;
            2:       send_idle_pct = 30;
            default: send_idle_pct = 60;
        endcase
        case ($urandom_range(0, 3))
            0:       recv_idle_pct = 0;
            1:       recv_idle_pct = 10;
            2:       recv_idle_pct = 30;
            default: recv_idle_pct = 60;
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic op, input logic [VALUE_W-1:0] value);
        if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic run_mix(input int count, input int push_pct);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0 && !quiet) begin
                pick_pressure();
            end
            send_item(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, rand_value());
        end
    endtask

    initial begin
        int n;
        sb            = new(CAPACITY);
        cycles        = 0;
        quiet         = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue, extremes and front refills
        send_item(OP_POP,  32'hffff_ffff);
        send_item(OP_PUSH, 32'h0000_0000);
        send_item(OP_POP,  32'h0000_0000);
        send_item(OP_POP,  32'h0000_0000);
        send_item(OP_PUSH, 32'h7fff_ffff);
        send_item(OP_PUSH, 32'h8000_0000);
        send_item(OP_PUSH, 32'hffff_ffff);
        send_item(OP_PUSH, 32'h0000_0001);
        send_item(OP_POP,  32'h0000_0000);
        send_item(OP_PUSH, 32'h5555_5555);
        send_item(OP_PUSH, 32'haaaa_aaaa);
        send_item(OP_POP,  32'h0000_0000);
        send_item(OP_POP,  32'h0000_0000);
        send_item(OP_PUSH, 32'h8000_0000);
        send_item(OP_POP,  32'h0000_0000);
        send_item(OP_POP,  32'h0000_0000);
        send_item(OP_POP,  32'h0000_0000);
        send_item(OP_POP,  32'h0000_0000);
        send_item(OP_POP,  32'hffff_ffff);

        for (int b = 0; b < 7; b++) begin
            run_mix(50, $urandom_range(20, 80));
        end

        // deep queue for a long refill
        run_mix(150, 90);

        // drain below empty
        n = 0;
        while (sb.occupancy() > 0) begin
            if (n % 100 == 0) begin
                pick_pressure();
            end
            send_item(OP_POP, rand_value());
            n++;
        end
        repeat (4) send_item(OP_POP, rand_value());

        for (int b = 0; b < 2; b++) begin
            run_mix(50, $urandom_range(20, 80));
        end

        quiet = 1'b1;
        run_mix(150, 55);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
